// File: src/ddf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddf_pkg;

  localparam int NUM_W      = 32;
  localparam int CNT_W      = 4;
  localparam int COORD_W    = 8;
  localparam int FONT_W     = 8;
  localparam int CHAR_W     = 6;
  localparam int DIG_W      = 4;
  localparam int MAX_DIGITS = 10;
  localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_W      = $clog2(NUM_W);

  localparam int IN_W  = 64;
  localparam int OUT_W = 32;

  localparam logic [FONT_W-1:0]  FONT_NARROW = 8'd1;
  localparam logic [COORD_W-1:0] ADV_NARROW  = 8'd6;
  localparam logic [COORD_W-1:0] ADV_WIDE    = 8'd8;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE  = 6'd32;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 6'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE   = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: src/decimal_digit_formatter.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: number, digit_count, start_x, start_y, font_code
// m        out  m_tvalid/m_tready  m_tdata: char_code, x_pos, y_pos, font_out; m_tlast: last
//
// one transaction in: it is accepted, converted through the row of bcd cells
// (one bit per cycle), then emitted as one character per m transfer, with
// digit_count characters in all (digit_count saturated at 10).
// rst is synchronous and clears the state machine and the output valid.
// a stalled m side holds the current character; the next number is taken
// while the last character of the previous one still waits.
`timescale 1ns / 1ps
`default_nettype none
module decimal_digit_formatter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // number[31:0], digit_count[35:32], start_x[43:36], start_y[51:44],
  // font_code[59:52], zero[63:60]
  input  wire logic [ddf_pkg::IN_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // char_code[5:0], x_pos[13:6], y_pos[21:14], font_out[29:22], zero[31:30]
  output logic [ddf_pkg::OUT_W-1:0]        m_tdata,
  output logic                             m_tlast
);

  ddf_pkg::state_t state, state_next;
  ddf_pkg::cell_ctl_t ctl;

  logic s_accept;
  logic emit_load;
  logic bit_done;

  logic [ddf_pkg::NUM_W-1:0]     in_number;
  logic [ddf_pkg::CNT_W-1:0]     in_count;
  logic [ddf_pkg::COORD_W-1:0]   in_x;
  logic [ddf_pkg::COORD_W-1:0]   in_y;
  logic [ddf_pkg::FONT_W-1:0]    in_font;
  logic [ddf_pkg::CNT_W-1:0]     count_sat;
  logic [ddf_pkg::CNT_W-1:0]     count_m1;

  logic [ddf_pkg::NUM_W-1:0]     num_sr;
  logic [ddf_pkg::BIT_W-1:0]     bit_cnt;
  logic [ddf_pkg::POS_W-1:0]     pos;
  logic [ddf_pkg::COORD_W-1:0]   x_cur;
  logic [ddf_pkg::COORD_W-1:0]   y_hold;
  logic [ddf_pkg::FONT_W-1:0]    font_hold;
  logic [ddf_pkg::COORD_W-1:0]   step;
  logic                          showing;

  logic [ddf_pkg::MAX_DIGITS:0]  carry;
  logic [ddf_pkg::DIG_W-1:0]     cell_digit [ddf_pkg::MAX_DIGITS];

  logic [ddf_pkg::DIG_W-1:0]     cur_digit;
  logic                          is_last;
  logic                          blank;
  logic [ddf_pkg::CHAR_W-1:0]    code;

  assign in_number = s_tdata[31:0];
  assign in_count  = s_tdata[35:32];
  assign in_x      = s_tdata[43:36];
  assign in_y      = s_tdata[51:44];
  assign in_font   = s_tdata[59:52];

  always_comb begin
    if (in_count > ddf_pkg::CNT_W'(ddf_pkg::MAX_DIGITS)) begin
      count_sat = ddf_pkg::CNT_W'(ddf_pkg::MAX_DIGITS);
    end else begin
      count_sat = in_count;
    end
  end

  assign count_m1 = count_sat - ddf_pkg::CNT_W'(1);
  assign s_accept = s_tvalid && s_tready;
  assign bit_done = (bit_cnt == ddf_pkg::BIT_W'(ddf_pkg::NUM_W - 1));

  // bcd cell row, lowest digit first; top carry out is dropped (mod 10^n)
  assign carry[0] = num_sr[ddf_pkg::NUM_W-1];

  for (genvar i = 0; i < ddf_pkg::MAX_DIGITS; i++) begin : g_cell
    ddf_digit_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (carry[i]),
      .shift_out (carry[i+1]),
      .digit     (cell_digit[i])
    );
  end

  assign cur_digit = cell_digit[pos];
  assign is_last   = (pos == '0);
  assign blank     = !showing && !is_last && (cur_digit == '0);
  assign code      = blank ? ddf_pkg::CHAR_SPACE
                           : (ddf_pkg::CHAR_ZERO + ddf_pkg::CHAR_W'(cur_digit));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ddf_pkg::ST_IDLE: begin
        if (s_accept && (count_sat != '0)) begin
          state_next = ddf_pkg::ST_CONVERT;
        end
      end
      ddf_pkg::ST_CONVERT: begin
        if (bit_done) begin
          state_next = ddf_pkg::ST_EMIT;
        end
      end
      ddf_pkg::ST_EMIT: begin
        if (emit_load && is_last) begin
          state_next = ddf_pkg::ST_IDLE;
        end
      end
      default: state_next = ddf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = 1'b0;
    ctl.shift = 1'b0;
    emit_load = 1'b0;
    unique case (state)
      ddf_pkg::ST_IDLE:    s_tready = 1'b1;
      ddf_pkg::ST_CONVERT: ctl.shift = 1'b1;
      ddf_pkg::ST_EMIT:    emit_load = !m_tvalid || m_tready;
      default: ;
    endcase
    ctl.clear = s_accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ddf_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      num_sr    <= in_number;
      bit_cnt   <= '0;
      pos       <= ddf_pkg::POS_W'(count_m1);
      x_cur     <= in_x;
      y_hold    <= in_y;
      font_hold <= in_font;
      step      <= (in_font == ddf_pkg::FONT_NARROW) ? ddf_pkg::ADV_NARROW : ddf_pkg::ADV_WIDE;
      showing   <= 1'b0;
    end else begin
      if (ctl.shift) begin
        num_sr  <= {num_sr[ddf_pkg::NUM_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + ddf_pkg::BIT_W'(1);
      end
      if (emit_load) begin
        m_tdata <= {2'b00, font_hold, y_hold, x_cur, code};
        m_tlast <= is_last;
        pos     <= pos - ddf_pkg::POS_W'(1);
        x_cur   <= x_cur + step;
        showing <= !blank;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (count_sat != '0)) |=> (state == ddf_pkg::ST_CONVERT))
    else $error("accepted number did not start conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_load && is_last) |=> (state == ddf_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("last character did not close the number");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:0] == ddf_pkg::CHAR_SPACE ||
                  (m_tdata[5:0] >= ddf_pkg::CHAR_ZERO && m_tdata[5:0] <= ddf_pkg::CHAR_NINE)))
    else $error("character code out of range");

  a_no_emit_converting: assert property (@(posedge clk) disable iff (rst)
    (state == ddf_pkg::ST_CONVERT) |-> !emit_load && !s_tready)
    else $error("emit or accept during conversion");
`endif

endmodule
`default_nettype wire

// File: src/ddf_digit_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ddf_digit_cell (
  input  wire logic                       clk,
  input  wire ddf_pkg::cell_ctl_t         ctl,
  input  wire logic                       shift_in,
  output logic                            shift_out,
  output logic [ddf_pkg::DIG_W-1:0]       digit
);

  logic [ddf_pkg::DIG_W-1:0] adj;

  // add 3 when the digit would pass 9 after doubling
  always_comb begin
    if (digit >= ddf_pkg::DIG_W'(5)) begin
      adj = digit + ddf_pkg::DIG_W'(3);
    end else begin
      adj = digit;
    end
  end

  assign shift_out = adj[ddf_pkg::DIG_W-1];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.shift) begin
      digit <= {adj[ddf_pkg::DIG_W-2:0], shift_in};
    end
  end

endmodule
`default_nettype wire

// File: verif/decimal_digit_formatter_test.sv
`timescale 1ns / 1ps
module decimal_digit_formatter_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int HOLD_CYCLES   = 800;
  localparam int HOLD_AFTER    = 150;
  localparam int DRAIN_CYCLES  = 60;

  typedef struct {
    logic [ddf_pkg::CHAR_W-1:0]  code;
    logic [ddf_pkg::COORD_W-1:0] x_pos;
    logic [ddf_pkg::COORD_W-1:0] y_pos;
    logic [ddf_pkg::FONT_W-1:0]  font_out;
    logic                        last;
  } char_item_t;

  class char_scoreboard;
    char_item_t pending_chars[$];
    int errors;
    int chars_checked;
    int blanks_seen;
    int numbers_taken;
    int empty_numbers;
    int saturated_numbers;

    function new();
      errors = 0;
      chars_checked = 0;
      blanks_seen = 0;
      numbers_taken = 0;
      empty_numbers = 0;
      saturated_numbers = 0;
    endfunction

    // expands one accepted number into its row of characters, most significant first
    function void add_number(logic [ddf_pkg::NUM_W-1:0] number,
                             logic [ddf_pkg::CNT_W-1:0] count,
                             logic [ddf_pkg::COORD_W-1:0] sx,
                             logic [ddf_pkg::COORD_W-1:0] sy,
                             logic [ddf_pkg::FONT_W-1:0] font);
      logic [ddf_pkg::DIG_W-1:0]   digits [ddf_pkg::MAX_DIGITS];
      logic [ddf_pkg::NUM_W-1:0]   rest;
      logic [ddf_pkg::COORD_W-1:0] step;
      int                          n;
      int                          p;
      bit                          showing;
      char_item_t                  c;
      numbers_taken++;
      if (count == 0) empty_numbers++;
      if (count > ddf_pkg::MAX_DIGITS) saturated_numbers++;
      n = (count > ddf_pkg::MAX_DIGITS) ? ddf_pkg::MAX_DIGITS : int'(count);
      step = (font == ddf_pkg::FONT_NARROW) ? ddf_pkg::ADV_NARROW : ddf_pkg::ADV_WIDE;
      rest = number;
      for (int i = 0; i < ddf_pkg::MAX_DIGITS; i++) begin
        digits[i] = ddf_pkg::DIG_W'(rest % 10);
        rest = rest / 10;
      end
      showing = 1'b0;
      for (int t = 0; t < n; t++) begin
        p = n - 1 - t;
        c.last = (t == n - 1);
        // leading zeros blank out, the final position always shows
        if (!showing && !c.last && digits[p] == 0) begin
          c.code = ddf_pkg::CHAR_SPACE;
        end else begin
          showing = 1'b1;
          c.code = ddf_pkg::CHAR_ZERO + ddf_pkg::CHAR_W'(digits[p]);
        end
        c.x_pos = ddf_pkg::COORD_W'(int'(sx) + int'(step) * t);
        c.y_pos = sy;
        c.font_out = font;
        pending_chars.push_back(c);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_char(logic [ddf_pkg::OUT_W-1:0] data, logic tlast);
      char_item_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character transaction: tdata=%h tlast=%b", data, tlast);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (want.code == ddf_pkg::CHAR_SPACE) blanks_seen++;
      compare_field("char_code", want.code, data[5:0]);
      compare_field("x_pos", want.x_pos, data[13:6]);
      compare_field("y_pos", want.y_pos, data[21:14]);
      compare_field("font_out", want.font_out, data[29:22]);
      compare_field("last", want.last, tlast);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [ddf_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [ddf_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tlast;

  char_scoreboard board;
  int cycle_count = 0;
  bit held_off = 1'b0;

  decimal_digit_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("decimal_digit_formatter_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_char(m_tdata, m_tlast);
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_number(input logic [ddf_pkg::NUM_W-1:0] number,
                             input logic [ddf_pkg::CNT_W-1:0] count,
                             input logic [ddf_pkg::COORD_W-1:0] sx,
                             input logic [ddf_pkg::COORD_W-1:0] sy,
                             input logic [ddf_pkg::FONT_W-1:0] font);
    s_tdata <= {4'b0, font, sy, sx, count, number};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.add_number(number, count, sx, sy, font);
    @(negedge clk);
  endtask

  // receiver: runs of always-ready, random ready, mostly-ready and short stalls
  initial begin
    int mode;
    int len;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && board.chars_checked >= HOLD_AFTER) begin
        // long hold-off so the block backs up and stalls its input
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(5, 60);
      repeat (len) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= 1'b0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [ddf_pkg::NUM_W-1:0]   number;
    logic [ddf_pkg::CNT_W-1:0]   count;
    logic [ddf_pkg::COORD_W-1:0] sx;
    logic [ddf_pkg::COORD_W-1:0] sy;
    logic [ddf_pkg::FONT_W-1:0]  font;
    logic [ddf_pkg::NUM_W-1:0]   scale;
    int sent;
    int burst;
    int gap;
    int pick;

    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single zero, blanks up to the last digit, extremes, truncation, saturation, wrap
    send_number(32'd0,          4'd1,  8'd0,   8'd0,   8'd0);
    send_number(32'd0,          4'd10, 8'd255, 8'd255, ddf_pkg::FONT_NARROW);
    send_number(32'hFFFFFFFF,   4'd10, 8'd0,   8'd0,   8'hFF);
    send_number(32'd1000000000, 4'd10, 8'd250, 8'd17,  ddf_pkg::FONT_NARROW);
    send_number(32'd12345,      4'd3,  8'd10,  8'd20,  8'd0);
    send_number(32'd100,        4'd5,  8'd0,   8'd0,   8'd2);
    send_number(32'd7,          4'd1,  8'd128, 8'd128, ddf_pkg::FONT_NARROW);
    send_number(32'd123,        4'd0,  8'd1,   8'd2,   8'd3);
    send_number(32'd4000000000, 4'd15, 8'd200, 8'd99,  8'd0);
    send_number(32'd42,         4'd11, 8'd240, 8'd5,   ddf_pkg::FONT_NARROW);
    send_number(32'd999999999,  4'd9,  8'd255, 8'd0,   8'hFE);
    send_number(32'd5,          4'd2,  8'd60,  8'd30,  ddf_pkg::FONT_NARROW);
    send_number(32'd10,         4'd2,  8'd61,  8'd31,  8'd8);
    send_number(32'd1234567890, 4'd10, 8'h55,  8'hAA,  8'h80);
    send_number(32'hFFFFFFFF,   4'd0,  8'hFF,  8'hFF,  8'hFF);
    send_number(32'd90,         4'd4,  8'hAA,  8'h55,  8'h7F);
    send_number(32'd0,          4'd13, 8'd3,   8'd4,   ddf_pkg::FONT_NARROW);
    send_number(32'd600,        4'd2,  8'd252, 8'd9,   8'd6);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0: number = $urandom;
          1: number = $urandom_range(0, 999);
          2: begin
            scale = 1;
            repeat ($urandom_range(0, 9)) scale = scale * 10;
            number = scale * $urandom_range(0, 4);
          end
          default: number = $urandom_range(0, 99999);
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) count = 4'd0;
        else if (pick == 1) count = $urandom_range(11, 15);
        else count = $urandom_range(1, ddf_pkg::MAX_DIGITS);
        sx = $urandom_range(0, 255);
        sy = $urandom_range(0, 255);
        font = $urandom_range(0, 1) ? ddf_pkg::FONT_NARROW
                                    : ddf_pkg::FONT_W'($urandom_range(0, 255));
        send_number(number, count, sx, sy, font);
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d numbers taken (%0d with no digits, %0d with a count above the maximum)",
             board.numbers_taken, board.empty_numbers, board.saturated_numbers);
    $display("%0d characters checked, %0d of them blanked leading zeros, long hold-off %s",
             board.chars_checked, board.blanks_seen, held_off ? "done" : "not reached");
    if (board.errors == 0) begin
      $display("decimal_digit_formatter_test: done, clean");
    end else begin
      $display("decimal_digit_formatter_test: done, errors");
    end
    $finish;
  end

endmodule

// File: decimal_digit_formatter.f
src/ddf_pkg.sv
src/ddf_digit_cell.sv
src/decimal_digit_formatter.sv
verif/decimal_digit_formatter_test.sv
